>>> src/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int SYS_W    = 64;
  localparam int PERIOD_W = 10;

  localparam logic [KIND_W-1:0] KIND_TICK       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_SIGNED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INS_REL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INS_ABS    = 2'd3;

  localparam logic STATUS_EXPIRED = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  localparam logic [TIME_W-1:0]   TIMEOUT_FOREVER = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0]   REACH_LIMIT     = 32'h7FFF_FFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 10'd1;

  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [ID_W-1:0]   ident;
    logic              notify;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_INS  = 3'b010,
    ST_POP  = 3'b100
  } state_t;

endpackage

>>> src/stq_cell.sv
`timescale 1ns / 1ps

module stq_cell (
  input  logic                        clk,
  input  stq_pkg::cell_ctl_t          ctl_i,
  input  stq_pkg::entry_t             prev_i,
  input  stq_pkg::entry_t             next_i,
  input  stq_pkg::entry_t             new_i,
  input  logic [stq_pkg::TIME_W-1:0]  key_i,
  input  logic [stq_pkg::TIME_W-1:0]  ofs_i,
  input  logic                        valid_i,
  input  logic                        found_i,
  output stq_pkg::entry_t             entry_o,
  output logic                        found_o
);
  import stq_pkg::*;

  entry_t            entry_r;
  entry_t            entry_nxt;
  logic [TIME_W-1:0] own_key;
  logic              take;
  logic              hit;

  // An empty cell, or one whose entry is strictly later than the new one,
  // is a candidate; the first candidate in the row receives the new entry.
  assign own_key = entry_r.tstamp - ofs_i;
  assign take    = !valid_i || (key_i < own_key);
  assign hit     = take && !found_i;
  assign found_o = found_i || take;
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.ins) begin
      if (hit) begin
        entry_nxt = new_i;
      end else if (found_i) begin
        entry_nxt = prev_i;
      end
    end else if (ctl_i.pop) begin
      entry_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> src/sorted_timer_event_queue.sv
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// input     in_kind, in_event_id, in_time_value,          start & !busy
//           in_has_callback
// result    out_expired_id, out_status, out_last,         out_valid, one cycle
//           out_tick_time
// config    cfg_wdata                                     cfg_we
//
// An insert forms the expiry key on acceptance and the cell row shifts in the
// next cycle, unless the row is full and the insert is dropped. A forever timeout is accepted without leaving idle.
// A tick advances the time on acceptance and then pops the head entries that are due;
// the row pops one entry per cycle. Reset clears time, count and control state.
// Results cannot be stalled; each is presented for exactly one cycle.
module sorted_timer_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [stq_pkg::KIND_W-1:0]    in_kind,
  input  logic [stq_pkg::ID_W-1:0]      in_event_id,
  input  logic [stq_pkg::TIME_W-1:0]    in_time_value,
  input  logic                          in_has_callback,
  input  logic                          cfg_we,
  input  logic [stq_pkg::PERIOD_W-1:0]  cfg_wdata,
  output logic                          out_valid,
  output logic [stq_pkg::ID_W-1:0]      out_expired_id,
  output logic                          out_status,
  output logic                          out_last,
  output logic [stq_pkg::TIME_W-1:0]    out_tick_time
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [SYS_W-1:0]    sys_time_r, sys_time_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [RES_W-1:0]    n_r, n_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  entry_t              new_r, new_nxt;
  logic [TIME_W-1:0]   key_r, key_nxt;
  logic [TIME_W-1:0]   ofs_r, ofs_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;

  logic [TIME_W-1:0]   cur_lo;
  logic [TIME_W-1:0]   rel_sum;
  logic                forever_tmo;
  logic                full;
  logic                reached;
  logic                pop_go;
  cell_ctl_t           ctl;
  entry_t              cell_q [QUEUE_DEPTH];
  logic                found [QUEUE_DEPTH+1];

  assign cur_lo      = sys_time_r[TIME_W-1:0];
  assign rel_sum     = in_time_value + TIME_W'(period_r);
  assign forever_tmo = (in_kind == KIND_INS_SIGNED) && (in_time_value == TIMEOUT_FOREVER);
  assign full        = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign reached     = ((cur_lo - cell_q[0].tstamp) <= REACH_LIMIT);
  assign pop_go      = (cnt_r != '0) && reached && (n_r < RES_W'(MAX_RESULTS));

  assign ctl.ins  = (state_r == ST_INS) && !full;
  assign ctl.pop  = (state_r == ST_POP) && pop_go;
  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    stq_cell u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .prev_i  ((i == 0) ? new_r : cell_q[(i == 0) ? 0 : i-1]),
      .next_i  (cell_q[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .new_i   (new_r),
      .key_i   (key_r),
      .ofs_i   (ofs_r),
      .valid_i (cnt_r > CNT_W'(i)),
      .found_i (found[i]),
      .entry_o (cell_q[i]),
      .found_o (found[i+1])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    sys_time_nxt   = sys_time_r;
    period_nxt     = period_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    new_nxt        = new_r;
    key_nxt        = key_r;
    ofs_nxt        = ofs_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_time_nxt   = out_time_r;

    if (cfg_we) begin
      period_nxt = cfg_wdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_kind == KIND_TICK) begin
            sys_time_nxt   = sys_time_r + SYS_W'(period_r);
            n_nxt          = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_POP;
          end else if (!forever_tmo) begin
            // Keys are offsets from a window that opens REACH_LIMIT
            // below the current time, so plain unsigned compares sort them.
            new_nxt.ident  = in_event_id;
            new_nxt.notify = in_has_callback;
            ofs_nxt        = cur_lo - REACH_LIMIT;
            if (in_kind == KIND_INS_ABS) begin
              new_nxt.tstamp = in_time_value;
              key_nxt        = in_time_value - cur_lo + REACH_LIMIT;
            end else begin
              new_nxt.tstamp = cur_lo + rel_sum;
              key_nxt        = rel_sum + REACH_LIMIT;
            end
            state_nxt = ST_INS;
          end
        end
      end
      ST_INS: begin
        if (full) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = new_r.ident;
          out_status_nxt = STATUS_DROPPED;
          out_last_nxt   = 1'b1;
          out_time_nxt   = cur_lo;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_POP: begin
        // A captured result is held back until the next one is captured or the pass ends,
        // so that the final one of the tick can be flagged as last.
        if (pop_go) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cell_q[0].notify) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_id_nxt     = pend_id_r;
              out_status_nxt = STATUS_EXPIRED;
              out_last_nxt   = 1'b0;
              out_time_nxt   = cur_lo;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = cell_q[0].ident;
            n_nxt          = n_r + RES_W'(1);
          end
        end else begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_id_nxt     = pend_id_r;
            out_status_nxt = STATUS_EXPIRED;
            out_last_nxt   = 1'b1;
            out_time_nxt   = cur_lo;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sys_time_r   <= '0;
      period_r     <= PERIOD_RESET;
      cnt_r        <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sys_time_r   <= sys_time_nxt;
      period_r     <= period_nxt;
      cnt_r        <= cnt_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r    <= pend_id_nxt;
    new_r        <= new_nxt;
    key_r        <= key_nxt;
    ofs_r        <= ofs_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_time_r   <= out_time_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_expired_id = out_id_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;
  assign out_tick_time  = out_time_r;

endmodule

>>> src/stq_chk.sv
`timescale 1ns / 1ps

module stq_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [stq_pkg::KIND_W-1:0]    in_kind,
  input logic                          out_valid,
  input logic                          out_status,
  input logic                          out_last
);
  import stq_pkg::*;

  // A tick always needs at least the pop pass.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_TICK) |=> busy)
    else $error("tick transaction did not make the block busy");

  // A dropped insert is a single-result transaction.
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_DROPPED) |-> out_last)
    else $error("drop result not marked last");

  // The final result of a transaction appears as the block goes idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("last result while still busy");

  // Results that are not last are expiries with more still to come.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (busy && out_status == STATUS_EXPIRED))
    else $error("non-last result outside a tick");

endmodule

bind sorted_timer_event_queue stq_chk u_stq_chk (.*);

>>> bench/stq_checker.sv
`timescale 1ns / 1ps

module stq_checker
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [ID_W-1:0]     in_event_id,
  input  logic [TIME_W-1:0]   in_time_value,
  input  logic                in_has_callback,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  input  logic                out_valid,
  input  logic [ID_W-1:0]     out_expired_id,
  input  logic                out_status,
  input  logic                out_last,
  input  logic [TIME_W-1:0]   out_tick_time,
  output int                  fail_count,
  output int                  n_pending,
  output int                  n_reports
);

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic              status;
    logic              last;
    logic [TIME_W-1:0] stamp;
  } report_t;

  logic [SYS_W-1:0]    sys_now;
  logic [PERIOD_W-1:0] period;
  entry_t              slot [QUEUE_DEPTH];
  int                  used;
  report_t             due_q [$];

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  function automatic void queue_event(logic [TIME_W-1:0] due, logic [ID_W-1:0] ident,
                                      logic notify);
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] new_key;
    logic [TIME_W-1:0] old_key;
    report_t           drop;
    int                pos;
    base = sys_now[TIME_W-1:0] - REACH_LIMIT;
    if (used >= QUEUE_DEPTH) begin
      drop.ident  = ident;
      drop.status = STATUS_DROPPED;
      drop.last   = 1'b1;
      drop.stamp  = sys_now[TIME_W-1:0];
      due_q.push_back(drop);
      return;
    end
    // Keys are compared as offsets from the start of the wraparound window, and a
    // new event lands behind every entry with the same expiry.
    new_key = due - base;
    pos = 0;
    while (pos < used) begin
      old_key = slot[pos].tstamp - base;
      if (new_key < old_key) break;
      pos++;
    end
    for (int i = used; i > pos; i--) slot[i] = slot[i-1];
    slot[pos].tstamp = due;
    slot[pos].ident  = ident;
    slot[pos].notify = notify;
    used++;
  endfunction

  function automatic void run_tick();
    logic [TIME_W-1:0] cur_low;
    logic [TIME_W-1:0] age;
    report_t           held;
    logic              have_held;
    int                n;
    sys_now   = sys_now + period;
    cur_low   = sys_now[TIME_W-1:0];
    have_held = 1'b0;
    n = 0;
    while (used > 0 && n < MAX_RESULTS) begin
      age = cur_low - slot[0].tstamp;
      if (age > REACH_LIMIT) break;
      if (slot[0].notify) begin
        // The newest report is held back so that it can carry the last flag.
        if (have_held) due_q.push_back(held);
        held.ident  = slot[0].ident;
        held.status = STATUS_EXPIRED;
        held.last   = 1'b0;
        held.stamp  = cur_low;
        have_held   = 1'b1;
        n++;
      end
      for (int i = 1; i < used; i++) slot[i-1] = slot[i];
      used--;
    end
    if (have_held) begin
      held.last = 1'b1;
      due_q.push_back(held);
    end
  endfunction

  function automatic void take_command();
    case (in_kind)
      KIND_TICK: begin
        run_tick();
      end
      KIND_INS_SIGNED: begin
        if (in_time_value != TIMEOUT_FOREVER)
          queue_event(sys_now[TIME_W-1:0] + in_time_value + period, in_event_id,
                      in_has_callback);
      end
      KIND_INS_REL: begin
        queue_event(sys_now[TIME_W-1:0] + in_time_value + period, in_event_id,
                    in_has_callback);
      end
      KIND_INS_ABS: begin
        queue_event(in_time_value, in_event_id, in_has_callback);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_report();
    report_t want;
    n_reports++;
    if (due_q.size() == 0) begin
      note_failure($sformatf("unexpected report: id=%0d status=%0d last=%0d time=%h",
                             out_expired_id, out_status, out_last, out_tick_time));
      return;
    end
    want = due_q.pop_front();
    if (want.ident !== out_expired_id || want.status !== out_status ||
        want.last !== out_last || want.stamp !== out_tick_time)
      note_failure($sformatf({"report mismatch: expected id=%0d status=%0d last=%0d ",
                              "time=%h, got id=%0d status=%0d last=%0d time=%h"},
                             want.ident, want.status, want.last, want.stamp,
                             out_expired_id, out_status, out_last, out_tick_time));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sys_now    = '0;
      period     = PERIOD_RESET;
      used       = 0;
      due_q.delete();
      fail_count = 0;
      n_pending  = 0;
      n_reports  = 0;
    end else begin
      // Reports leave before a new command is taken, so a report in the same
      // cycle as an acceptance always belongs to an older transaction.
      if (out_valid) check_report();
      if (cfg_we) period = cfg_wdata;
      if (start && !busy) take_command();
      n_pending = due_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stq_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = 24;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   in_kind         = KIND_TICK;
  logic [ID_W-1:0]     in_event_id     = '0;
  logic [TIME_W-1:0]   in_time_value   = '0;
  logic                in_has_callback = 1'b0;
  logic                cfg_we          = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata       = '0;
  logic                out_valid;
  logic [ID_W-1:0]     out_expired_id;
  logic                out_status;
  logic                out_last;
  logic [TIME_W-1:0]   out_tick_time;

  int fail_count;
  int n_pending;
  int n_reports;

  // Low word of the block's clock, tracked only to aim absolute times.
  logic [TIME_W-1:0]   now_est    = '0;
  logic [PERIOD_W-1:0] cur_period = PERIOD_RESET;
  int n_items    = 0;
  int n_ticks    = 0;
  int n_inserts  = 0;
  int n_settings = 0;
  int far_budget = 0;

  always #1 clk = ~clk;

  sorted_timer_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_event_id     (in_event_id),
    .in_time_value   (in_time_value),
    .in_has_callback (in_has_callback),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_expired_id  (out_expired_id),
    .out_status      (out_status),
    .out_last        (out_last),
    .out_tick_time   (out_tick_time)
  );

  stq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_event_id     (in_event_id),
    .in_time_value   (in_time_value),
    .in_has_callback (in_has_callback),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_expired_id  (out_expired_id),
    .out_status      (out_status),
    .out_last        (out_last),
    .out_tick_time   (out_tick_time),
    .fail_count      (fail_count),
    .n_pending       (n_pending),
    .n_reports       (n_reports)
  );

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] ident,
                           input logic [TIME_W-1:0] tv, input logic cb);
    start           <= 1'b1;
    in_kind         <= kind;
    in_event_id     <= ident;
    in_time_value   <= tv;
    in_has_callback <= cb;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (kind == KIND_TICK) begin
      n_ticks++;
      now_est = now_est + cur_period;
    end else begin
      n_inserts++;
    end
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_reports();
    int waited;
    start <= 1'b0;
    @(posedge clk);
    waited = 1;
    while ((n_pending != 0 || busy) && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // Silent pops can keep the row working after the last report.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_period = value;
    n_settings++;
  endtask

  task automatic random_item();
    int unsigned       roll;
    logic [TIME_W-1:0] tv;
    logic [TIME_W-1:0] offset;
    logic [ID_W-1:0]   ident;
    logic              cb;
    roll  = $urandom_range(0, 99);
    ident = ID_W'($urandom);
    tv    = $urandom;
    cb    = ($urandom_range(0, 3) != 0);
    if (roll < 35) begin
      send_item(KIND_TICK, ident, tv, cb);
    end else if (roll < 72) begin
      tv = $urandom_range(0, 2 * cur_period + 2);
      send_item(roll[0] ? KIND_INS_SIGNED : KIND_INS_REL, ident, tv, cb);
    end else if (roll < 84) begin
      send_item(KIND_INS_ABS, ident, now_est + $urandom_range(0, 3 * cur_period + 3), cb);
    end else if (roll < 92) begin
      // Already behind the clock by less than half the range, so the next tick takes it.
      send_item(KIND_INS_ABS, ident, now_est - (tv & 32'h7FFF_F000), cb);
    end else if (roll < 95) begin
      send_item(KIND_INS_SIGNED, ident, TIMEOUT_FOREVER, cb);
    end else if (roll < 98) begin
      // Negative timeouts and relative values that wrap both fall behind the next tick's time.
      send_item(roll[0] ? KIND_INS_SIGNED : KIND_INS_REL, ident,
                TIMEOUT_FOREVER - $urandom_range(1, 4000), cb);
    end else if (far_budget > 0) begin
      // Just outside the reach window; such entries stay queued for the whole run,
      // so only a few are let in.
      far_budget--;
      offset = roll[0] ? '0 : (tv & 32'h000F_FFFF);
      send_item(KIND_INS_ABS, ident, now_est + cur_period + 32'h8000_0000 - offset, cb);
    end else begin
      send_item(KIND_TICK, ident, tv, cb);
    end
  endtask

  task automatic traffic_burst();
    int len;
    len = $urandom_range(1, 8);
    repeat (len) random_item();
    if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
  endtask

  // Two more inserts than the row holds: at least the extra ones come back as drops,
  // and the tick then expires every flood entry that got in.
  task automatic flood_queue();
    logic [ID_W-1:0] ident;
    repeat (QUEUE_DEPTH + 2) begin
      ident = ID_W'($urandom);
      send_item(KIND_INS_REL, ident, '0, 1'b1);
    end
    send_item(KIND_TICK, ident, '0, 1'b0);
  endtask

  initial begin
    int phase;
    int phase_start;
    int errors;
    logic [PERIOD_W-1:0] next_period;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_period(PERIOD_RESET);

    // Directed cases at a period of one.
    send_item(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_INS_SIGNED, 8'h11, TIMEOUT_FOREVER, 1'b1);
    send_item(KIND_INS_SIGNED, 8'h00, 32'h0000_0000, 1'b1);
    send_item(KIND_INS_REL, 8'hA5, 32'h0000_0000, 1'b0);
    send_item(KIND_INS_ABS, 8'hFF, now_est + cur_period, 1'b1);
    send_item(KIND_INS_SIGNED, 8'h5A, 32'hFFFF_FFFE, 1'b1);
    send_item(KIND_INS_ABS, 8'h3C, now_est + cur_period - REACH_LIMIT, 1'b1);
    send_item(KIND_INS_REL, 8'hC3, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_INS_REL, 8'h0F, 32'h0000_0003, 1'b1);
    hold_off(3);
    send_item(KIND_TICK, 8'h00, 32'h0000_0000, 1'b0);
    send_item(KIND_TICK, 8'h81, 32'h8000_0001, 1'b0);
    hold_off(1);
    send_item(KIND_TICK, 8'h7E, 32'h7FFF_FFFE, 1'b1);
    send_item(KIND_TICK, 8'h00, 32'h0000_0000, 1'b0);
    send_item(KIND_TICK, 8'h00, 32'h0000_0000, 1'b0);

    phase = 0;
    while (n_items < 100 && phase < 30) begin
      drain_reports();
      case (phase % 5)
        0: next_period = 10'd1000;
        1: next_period = 10'd0;
        2: next_period = 10'd1023;
        3: next_period = PERIOD_W'($urandom_range(1, 1000));
        default: next_period = 10'd1;
      endcase
      write_period(next_period);
      if (phase == 0 || $urandom_range(0, 3) == 0) flood_queue();
      if (phase == 0) far_budget = 3;
      phase_start = n_items;
      while (n_items - phase_start < 20) traffic_burst();
      phase++;
    end

    drain_reports();
    errors = fail_count + n_pending;
    $display("Run covered %0d transactions (%0d ticks, %0d inserts) over %0d period settings.",
             n_items, n_ticks, n_inserts, n_settings);
    $display("%0d reports were checked; %0d mismatches or missing reports.",
             n_reports, errors);
    if (errors == 0) begin
      $display("sorted_timer_event_queue regression: pass");
    end else begin
      $display("sorted_timer_event_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sorted_timer_event_queue regression: fail");
    $finish;
  end

endmodule
